// ===== hdl/bresenham_line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Bresenham line rasterizer - assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// Checked only while out of reset.
`define BLR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blr assertion failed");

// Checked at every edge, reset included.
`define BLR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("blr assertion failed");

`endif

// ===== hdl/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// Types and constants shared across the line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int COORD_BITS_DEF = 12;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } item_kind_t;

  // input register -> step unit
  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } in_ctl_t;

  // step unit -> result register
  typedef struct packed {
    logic emit;
    logic last;
  } res_ctl_t;

endpackage

// ===== hdl/blr_ifs.sv =====
// ----------------------------------------------------------------------------
// blr channel interfaces
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface blr_in_if #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
  import blr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blr_out_if #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
);
  import blr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ===== hdl/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line rasterizer: load endpoints, one pixel per tick while a line is active.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_chan   in   valid / ready   kind, start_x, start_y, end_x, end_y
//  out_chan  out  valid / ready   pixel_x, pixel_y, last_pixel
//
//  One transaction per clock sustained while out_chan is not stalled; a tick's
//  pixel reaches out_chan through the input register, then the result register.
//  Throughput is set by the single add/compare on the decision register.
//  rst_n (synchronous) empties both registers and idles the line state.
//  Output stalls back up through the input register to in_chan.ready.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  blr_in_if.sink     in_chan,
  blr_out_if.source  out_chan
);
  import blr_pkg::*;

  in_ctl_t               ctl;
  res_ctl_t              res;
  logic                  advance;
  logic                  space;
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] px, py;

  blr_in_stage #(.COORD_BITS(COORD_BITS)) u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .ctl     (ctl),
    .sx      (sx),
    .sy      (sy),
    .ex      (ex),
    .ey      (ey)
  );

  blr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sx      (sx),
    .sy      (sy),
    .ex      (ex),
    .ey      (ey),
    .space   (space),
    .advance (advance),
    .res     (res),
    .px      (px),
    .py      (py)
  );

  blr_out_stage #(.COORD_BITS(COORD_BITS)) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .res      (res),
    .px       (px),
    .py       (py),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule

// ===== hdl/blr_in_stage.sv =====
// ----------------------------------------------------------------------------
// blr_in_stage
// Input register: captures one transaction, releases it on advance.
// ----------------------------------------------------------------------------
module blr_in_stage #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  blr_in_if.sink                  in_chan,
  input  logic                    advance,
  output blr_pkg::in_ctl_t        ctl,
  output logic [COORD_BITS-1:0]   sx,
  output logic [COORD_BITS-1:0]   sy,
  output logic [COORD_BITS-1:0]   ex,
  output logic [COORD_BITS-1:0]   ey
);
  import blr_pkg::*;

  logic                  valid_r;
  item_kind_t            kind_r;
  logic [COORD_BITS-1:0] sx_r;
  logic [COORD_BITS-1:0] sy_r;
  logic [COORD_BITS-1:0] ex_r;
  logic [COORD_BITS-1:0] ey_r;
  logic                  take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= item_kind_t'(in_chan.kind);
      sx_r   <= in_chan.start_x;
      sy_r   <= in_chan.start_y;
      ex_r   <= in_chan.end_x;
      ey_r   <= in_chan.end_y;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.kind  = kind_r;
  assign sx        = sx_r;
  assign sy        = sy_r;
  assign ex        = ex_r;
  assign ey        = ey_r;

endmodule

// ===== hdl/blr_step.sv =====
// ----------------------------------------------------------------------------
// blr_step
// Line state and one Bresenham step: load sets up, tick emits a pixel while a line is active.
// ----------------------------------------------------------------------------
module blr_step #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  blr_pkg::in_ctl_t        ctl,
  input  logic [COORD_BITS-1:0]   sx,
  input  logic [COORD_BITS-1:0]   sy,
  input  logic [COORD_BITS-1:0]   ex,
  input  logic [COORD_BITS-1:0]   ey,
  input  logic                    space,
  output logic                    advance,
  output blr_pkg::res_ctl_t       res,
  output logic [COORD_BITS-1:0]   px,
  output logic [COORD_BITS-1:0]   py
);
  import blr_pkg::*;

  localparam int DEC_W = COORD_BITS + 3;
  localparam int DLT_W = COORD_BITS + 1;

  logic                    active_r;
  logic                    steep_r;
  logic                    minor_down_r;
  logic [COORD_BITS-1:0]   cur_x_r;
  logic [COORD_BITS-1:0]   cur_y_r;
  logic [COORD_BITS-1:0]   major_end_r;
  logic signed [DEC_W-1:0] decision_r;
  logic [DLT_W-1:0]        tmin_r;
  logic [DLT_W-1:0]        tmaj_r;

  // load setup
  logic [COORD_BITS-1:0]   adx;
  logic [COORD_BITS-1:0]   ady;
  logic                    ld_steep;
  logic                    ld_swap;
  logic [COORD_BITS-1:0]   s0x, s0y, e0x, e0y;
  logic [COORD_BITS-1:0]   major_d;
  logic [COORD_BITS-1:0]   minor_d;
  logic [DLT_W-1:0]        ld_tmin;
  logic signed [DEC_W-1:0] ld_dec;

  // tick step
  logic                    is_tick;
  logic                    last;
  logic                    go_minor;
  logic [COORD_BITS-1:0]   x_minor;
  logic [COORD_BITS-1:0]   y_minor;
  logic signed [DEC_W-1:0] dec_nxt;

  always_comb begin
    adx      = (sx > ex) ? (sx - ex) : (ex - sx);
    ady      = (sy > ey) ? (sy - ey) : (ey - sy);
    ld_steep = !(ady < adx);
    ld_swap  = ld_steep ? (sy > ey) : (sx > ex);
    s0x      = ld_swap ? ex : sx;
    s0y      = ld_swap ? ey : sy;
    e0x      = ld_swap ? sx : ex;
    e0y      = ld_swap ? sy : ey;
    major_d  = ld_steep ? ady : adx;
    minor_d  = ld_steep ? adx : ady;
    ld_tmin  = {minor_d, 1'b0};
    ld_dec   = $signed({2'b00, ld_tmin}) - $signed({3'b000, major_d});
  end

  always_comb begin
    is_tick  = (ctl.kind == KIND_TICK);
    last     = (steep_r ? cur_y_r : cur_x_r) == major_end_r;
    go_minor = (decision_r > $signed(DEC_W'(0)));
    x_minor  = minor_down_r ? (cur_x_r - 1'b1) : (cur_x_r + 1'b1);
    y_minor  = minor_down_r ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);
    dec_nxt  = decision_r + $signed({2'b00, tmin_r})
             - (go_minor ? $signed({2'b00, tmaj_r}) : $signed(DEC_W'(0)));
  end

  assign advance  = ctl.valid && space;
  assign res.emit = is_tick && active_r;
  assign res.last = last;
  assign px       = cur_x_r;
  assign py       = cur_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (advance) begin
      if (!is_tick) begin
        active_r <= 1'b1;
      end else if (active_r && last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!is_tick) begin
        steep_r      <= ld_steep;
        minor_down_r <= ld_steep ? (e0x < s0x) : (e0y < s0y);
        major_end_r  <= ld_steep ? e0y : e0x;
        cur_x_r      <= s0x;
        cur_y_r      <= s0y;
        tmin_r       <= ld_tmin;
        tmaj_r       <= {major_d, 1'b0};
        decision_r   <= ld_dec;
      end else if (active_r && !last) begin
        if (steep_r) begin
          cur_y_r <= cur_y_r + 1'b1;
          if (go_minor) begin
            cur_x_r <= x_minor;
          end
        end else begin
          cur_x_r <= cur_x_r + 1'b1;
          if (go_minor) begin
            cur_y_r <= y_minor;
          end
        end
        decision_r <= dec_nxt;
      end
    end
  end

endmodule

// ===== hdl/blr_out_stage.sv =====
// ----------------------------------------------------------------------------
// blr_out_stage
// Result register: holds one pixel until the sink takes it.
// ----------------------------------------------------------------------------
module blr_out_stage #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  blr_pkg::res_ctl_t       res,
  input  logic [COORD_BITS-1:0]   px,
  input  logic [COORD_BITS-1:0]   py,
  output logic                    space,
  blr_out_if.source               out_chan
);
  import blr_pkg::*;

  logic                  valid_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic                  last_r;
  logic                  load;

  assign space = !valid_r || out_chan.ready;
  assign load  = advance && res.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px;
      py_r   <= py;
      last_r <= res.last;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.pixel_x    = px_r;
  assign out_chan.pixel_y    = py_r;
  assign out_chan.last_pixel = last_r;

endmodule

// ===== hdl/blr_checker.sv =====
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks on the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_rasterizer_defines.svh"

module blr_checker #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic                  last_pixel
);
  import blr_pkg::*;

  logic out_stall;
  assign out_stall = out_valid && !out_ready;

  `BLR_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid)
  `BLR_ASSERT(a_out_stable, clk, rst_n, out_stall |=> $stable({pixel_x, pixel_y, last_pixel}))
  // free result slot must open the input side
  `BLR_ASSERT(a_ready_chain, clk, rst_n, (out_ready || !out_valid) |-> in_ready)
  `BLR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .pixel_x    (out_chan.pixel_x),
  .pixel_y    (out_chan.pixel_y),
  .last_pixel (out_chan.last_pixel)
);

// ===== tb/sv/blr_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// blr_pixel_checker
// Watches the line command and pixel channels of the rasterizer. Every
// accepted command runs through a Bresenham line model kept here, and the
// pixels that model emits are queued. Every accepted output pixel is compared
// field by field against the oldest queued pixel.
// ----------------------------------------------------------------------------
module blr_pixel_checker (
  input  logic  clk,
  input  logic  rst_n,
  blr_in_if     in_mon,
  blr_out_if    out_mon,
  output int    fail_count,
  output int    pending_pixels
);
  timeunit 1ns;
  timeprecision 1ps;

  import blr_pkg::*;

  localparam int CB = COORD_BITS_DEF;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  pixel_t expected_pixels[$];

  // line walker state
  logic                 line_active;
  logic                 line_steep;
  logic                 minor_dec;
  coord_t               pos_x;
  coord_t               pos_y;
  coord_t               major_stop;
  logic signed [CB+2:0] err_term;
  logic [CB:0]          minor_inc2;
  logic [CB:0]          major_inc2;

  function automatic coord_t coord_dist(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic start_line(input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey);
    coord_t adx;
    coord_t ady;
    coord_t tmp;
    coord_t major_d;
    coord_t minor_d;
    logic   flip;
    adx = coord_dist(sx, ex);
    ady = coord_dist(sy, ey);
    line_steep = !(ady < adx);
    flip = line_steep ? (sy > ey) : (sx > ex);
    if (flip) begin
      tmp = sx; sx = ex; ex = tmp;
      tmp = sy; sy = ey; ey = tmp;
    end
    if (line_steep) begin
      minor_dec  = ex < sx;
      major_stop = ey;
      major_d    = ady;
      minor_d    = adx;
    end else begin
      minor_dec  = ey < sy;
      major_stop = ex;
      major_d    = adx;
      minor_d    = ady;
    end
    pos_x       = sx;
    pos_y       = sy;
    minor_inc2  = {minor_d, 1'b0};
    major_inc2  = {major_d, 1'b0};
    err_term    = $signed({2'b00, minor_d, 1'b0}) - $signed({3'b000, major_d});
    line_active = 1'b1;
  endtask

  task automatic emit_pixel();
    pixel_t px;
    logic   go_minor;
    if (!line_active)
      return;
    px.x    = pos_x;
    px.y    = pos_y;
    px.last = ((line_steep ? pos_y : pos_x) == major_stop);
    expected_pixels.push_back(px);
    if (px.last) begin
      line_active = 1'b0;
      return;
    end
    go_minor = err_term > 0;
    if (line_steep) begin
      pos_y = pos_y + 1'b1;
      if (go_minor)
        pos_x = minor_dec ? pos_x - 1'b1 : pos_x + 1'b1;
    end else begin
      pos_x = pos_x + 1'b1;
      if (go_minor)
        pos_y = minor_dec ? pos_y - 1'b1 : pos_y + 1'b1;
    end
    if (go_minor)
      err_term = err_term + $signed({2'b00, minor_inc2}) - $signed({2'b00, major_inc2});
    else
      err_term = err_term + $signed({2'b00, minor_inc2});
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      line_active = 1'b0;
      line_steep  = 1'b0;
      minor_dec   = 1'b0;
      pos_x       = '0;
      pos_y       = '0;
      major_stop  = '0;
      err_term    = '0;
      minor_inc2  = '0;
      major_inc2  = '0;
      expected_pixels.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                    out_mon.pixel_x, out_mon.pixel_y, out_mon.last_pixel));
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pixel_x !== want.x)
            report_mismatch($sformatf("pixel_x got %0d want %0d", out_mon.pixel_x, want.x));
          if (out_mon.pixel_y !== want.y)
            report_mismatch($sformatf("pixel_y got %0d want %0d", out_mon.pixel_y, want.y));
          if (out_mon.last_pixel !== want.last)
            report_mismatch($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
                                      out_mon.last_pixel, want.last, want.x, want.y));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_TICK)
          emit_pixel();
        else
          start_line(in_mon.start_x, in_mon.start_y, in_mon.end_x, in_mon.end_y);
      end
    end
    pending_pixels <= expected_pixels.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the line rasterizer: a directed pass over corner endpoints,
// slope classes and idle ticks, then random line commands (mostly complete
// short lines, some interrupted or long ones, some stray ticks) with random
// gaps on both channels and one long output stall. Checking is done by
// blr_pixel_checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blr_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int NUM_ITEMS = 1850;

  typedef logic [CB-1:0] coord_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_pixels;
  int   items_sent;
  int   pixels_taken;
  bit   tx_quiet;
  bit   rx_quiet;
  bit   hold_off;
  bit   hold_done;

  blr_in_if  #(.COORD_BITS(CB)) in_chan ();
  blr_out_if #(.COORD_BITS(CB)) out_chan ();

  bresenham_line_rasterizer #(.COORD_BITS(CB)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  blr_pixel_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("bresenham_line_rasterizer test failed");
    $finish;
  end

  function automatic int coord_gap(coord_t a, coord_t b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic int line_pixels(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int adx;
    int ady;
    adx = coord_gap(sx, ex);
    ady = coord_gap(sy, ey);
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  function automatic coord_t near_coord(coord_t c, int span);
    int lo;
    int hi;
    lo = int'(c) - span;
    hi = int'(c) + span;
    if (lo < 0) lo = 0;
    if (hi > (1 << CB) - 1) hi = (1 << CB) - 1;
    return coord_t'($urandom_range(lo, hi));
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic k, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    int gap;
    gap = (tx_quiet || hold_off) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.kind    <= k;
    in_chan.start_x <= sx;
    in_chan.start_y <= sy;
    in_chan.end_x   <= ex;
    in_chan.end_y   <= ey;
    in_chan.valid   <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_load(input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    send_item(KIND_LOAD, sx, sy, ex, ey);
  endtask

  // tick payload is don't-care, so it carries noise
  task automatic send_ticks(input int n);
    repeat (n)
      send_item(KIND_TICK, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom));
  endtask

  // pixel receiver
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (pixels_taken >= 400 && !hold_done) begin
        hold_done = 1'b1;
        hold_off  = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
      pixels_taken++;
      if (pixels_taken % 64 == 0)
        rx_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // line command source
  initial begin
    int     sel;
    int     n;
    int     span;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;

    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.kind    <= KIND_LOAD;
    in_chan.start_x <= '0;
    in_chan.start_y <= '0;
    in_chan.end_x   <= '0;
    in_chan.end_y   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_ticks(1);                          // tick with no line loaded
    send_load(12'd0, 12'd0, 12'd0, 12'd0);  // single point
    send_ticks(1);
    send_load('1, '1, '0, '0);              // steep diagonal, endpoints swapped
    send_ticks(1);
    send_load('1, '0, '0, '1);              // replaces line in progress
    send_ticks(1);
    send_load(12'd10, 12'd5, 12'd3, 12'd8); // shallow, y stepping down
    send_ticks(8);
    send_ticks(1);                          // tick after last pixel
    send_load(12'd7, 12'd9, 12'd7, 12'd6);  // vertical
    send_ticks(4);
    send_load(12'd5, 12'd5, 12'd7, 12'd3);  // |dx| == |dy|
    send_ticks(3);

    // random
    while (items_sent < NUM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        span = ($urandom_range(0, 24) == 0) ? 150 : 12;
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = near_coord(sx, span);
        ey = near_coord(sy, span);
        send_load(sx, sy, ex, ey);
        n = line_pixels(sx, sy, ex, ey);
        if ($urandom_range(0, 4) == 0)
          n += $urandom_range(1, 3);
        send_ticks(n);
      end else if (sel < 92) begin
        sx = pick_coord();
        sy = pick_coord();
        ex = pick_coord();
        ey = pick_coord();
        send_load(sx, sy, ex, ey);
        n = line_pixels(sx, sy, ex, ey);
        if (n > 6) n = 6;
        send_ticks($urandom_range(0, n));
      end else begin
        send_ticks($urandom_range(1, 3));
      end
    end

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("bresenham_line_rasterizer test passed");
    else
      $display("bresenham_line_rasterizer test failed");
    $finish;
  end

endmodule
